[design/pwmt_pkg.sv]
// Shared types and constants of the PWM timer register block.
// Holds command codes, decoded operation and result types. No dependencies.
package pwmt_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int COUNT_WIDTH_DEF  = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam int DATA_W   = 32;
   localparam int OFFSET_W = 8;
   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 4;   // channel field of an offset: offset[7:4] - 1
   localparam int CTRL_W   = 4;   // control bits kept
   localparam int CTRL_EN_BIT = 0;

   localparam logic [OFFSET_W-1:0] GLOBAL_OFFSET = 8'h00;
   localparam logic [OFFSET_W-1:0] CHAN_BASE     = 8'h10;

   // channel register offsets within a 0x10 window
   localparam logic [3:0] REG_CTRL   = 4'h0;
   localparam logic [3:0] REG_PERIOD = 4'h4;
   localparam logic [3:0] REG_DUTY   = 4'h8;
   localparam logic [3:0] REG_COUNT  = 4'hC;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OPK_TICK,
      OPK_READ,
      OPK_WRITE,
      OPK_NOP
   } op_kind_type;

   typedef enum logic [2:0] {
      TGT_GLOBAL,
      TGT_CTRL,
      TGT_PERIOD,
      TGT_DUTY,
      TGT_COUNT,
      TGT_BAD
   } target_type;

   typedef struct packed {
      op_kind_type        kind;
      target_type         target;
      logic [CHAN_W-1:0]  chan;
      logic [DATA_W-1:0]  wdata;
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              bad_access;
      logic              timer_running;
   } rsp_type;

endpackage

[design/pwmt_fifo.sv]
// Small register-based queue used between the stages of the PWM timer.
// Standalone; no package dependency.
module pwmt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[design/pwmt_front.sv]
// Front stage of the PWM timer: classifies each incoming item.
// Depends on pwmt_pkg for command codes and the decoded operation type.
module pwmt_front #(
   parameter int NUM_CHANNELS = pwmt_pkg::NUM_CHANNELS_DEF
) (
   input  logic [pwmt_pkg::CMD_W-1:0]    cmd,
   input  logic [pwmt_pkg::OFFSET_W-1:0] offset,
   input  logic [pwmt_pkg::DATA_W-1:0]   wdata,
   output pwmt_pkg::op_type              op
);
   import pwmt_pkg::*;

   localparam logic [CHAN_W:0] NumChan = (CHAN_W + 1)'(NUM_CHANNELS);

   logic [CHAN_W-1:0] chan;
   logic [3:0]        reg_sel;
   logic              is_write;
   target_type        chan_target;

   assign chan     = offset[7:4] - 4'd1;
   assign reg_sel  = offset[3:0];
   assign is_write = (cmd == CMD_WRITE);

   always_comb begin
      unique case (reg_sel)
         REG_CTRL:   chan_target = TGT_CTRL;
         REG_PERIOD: chan_target = TGT_PERIOD;
         REG_DUTY:   chan_target = TGT_DUTY;
         REG_COUNT:  chan_target = is_write ? TGT_BAD : TGT_COUNT;
         default:    chan_target = TGT_BAD;
      endcase
   end

   always_comb begin
      op.chan  = chan;
      op.wdata = wdata;
      if (offset == GLOBAL_OFFSET) begin
         op.target = TGT_GLOBAL;
      end else if (offset < CHAN_BASE || {1'b0, chan} >= NumChan) begin
         op.target = TGT_BAD;
      end else begin
         op.target = chan_target;
      end
      unique case (cmd)
         CMD_TICK:  op.kind = OPK_TICK;
         CMD_READ:  op.kind = OPK_READ;
         CMD_WRITE: op.kind = OPK_WRITE;
         default:   op.kind = OPK_NOP;
      endcase
   end

endmodule

[design/pwmt_back.sv]
// Back stage of the PWM timer: register file, channel counters and execution.
// Depends on pwmt_pkg for the operation and result types.
module pwmt_back #(
   parameter int NUM_CHANNELS = pwmt_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = pwmt_pkg::COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  pwmt_pkg::op_type  op,
   output pwmt_pkg::rsp_type rsp
);
   import pwmt_pkg::*;

   logic [NUM_CHANNELS-1:0] enable_ff, enable_in;
   logic [NUM_CHANNELS-1:0] done_ff, done_in;
   logic [CTRL_W-1:0]       control_ff [NUM_CHANNELS];
   logic [CTRL_W-1:0]       control_in [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  period_ff  [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  period_in  [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  duty_ff    [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  duty_in    [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  count_ff   [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  count_in   [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  count_inc  [NUM_CHANNELS];
   logic [DATA_W-1:0]       rd_chan;

   // read mux over the addressed channel
   always_comb begin
      rd_chan = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (op.chan == CHAN_W'(c)) begin
            case (op.target)
               TGT_CTRL:   rd_chan = DATA_W'(control_ff[c]);
               TGT_PERIOD: rd_chan = DATA_W'(period_ff[c]);
               TGT_DUTY:   rd_chan = DATA_W'(duty_ff[c]);
               TGT_COUNT:  rd_chan = DATA_W'(count_ff[c]);
               default:    rd_chan = '0;
            endcase
         end
      end
   end

   always_comb begin
      enable_in = enable_ff;
      done_in   = done_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         control_in[c] = control_ff[c];
         period_in[c]  = period_ff[c];
         duty_in[c]    = duty_ff[c];
         count_in[c]   = count_ff[c];
         count_inc[c]  = count_ff[c] + 1'b1;
      end
      rsp.rdata      = '0;
      rsp.bad_access = 1'b0;

      if (go) begin
         unique case (op.kind)
            OPK_TICK: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (enable_ff[c]) begin
                     if (period_ff[c] != '0 && count_inc[c] >= period_ff[c]) begin
                        count_in[c] = '0;
                        done_in[c]  = 1'b1;
                     end else begin
                        count_in[c] = count_inc[c];
                     end
                  end
               end
            end
            OPK_READ: begin
               if (op.target == TGT_GLOBAL) begin
                  rsp.rdata = DATA_W'({done_ff, enable_ff});
               end else if (op.target == TGT_BAD) begin
                  rsp.bad_access = 1'b1;
               end else begin
                  rsp.rdata = rd_chan;
               end
            end
            OPK_WRITE: begin
               if (op.target == TGT_GLOBAL) begin
                  // write one to clear the done flags
                  done_in = done_ff & ~op.wdata[2*NUM_CHANNELS-1:NUM_CHANNELS];
               end else if (op.target == TGT_BAD) begin
                  rsp.bad_access = 1'b1;
               end else begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (op.chan == CHAN_W'(c)) begin
                        case (op.target)
                           TGT_CTRL: begin
                              control_in[c] = op.wdata[CTRL_W-1:0];
                              enable_in[c]  = op.wdata[CTRL_EN_BIT];
                           end
                           TGT_PERIOD: period_in[c] = op.wdata[COUNT_WIDTH-1:0];
                           TGT_DUTY:   duty_in[c]   = op.wdata[COUNT_WIDTH-1:0];
                           default:    ;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      rsp.timer_running = |enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         done_ff   <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            control_ff[c] <= '0;
            period_ff[c]  <= '0;
            duty_ff[c]    <= '0;
            count_ff[c]   <= '0;
         end
      end else begin
         enable_ff <= enable_in;
         done_ff   <= done_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            control_ff[c] <= control_in[c];
            period_ff[c]  <= period_in[c];
            duty_ff[c]    <= duty_in[c];
            count_ff[c]   <= count_in[c];
         end
      end
   end

endmodule

[design/pwm_timer_register_block_core.sv]
// PWM timer register block, top level: classify, queue, execute, queue.
// Each item waits in the op queue and its result in the result queue before the result can be popped.
// Throughput: one item per cycle; the back stage executes one op per cycle and
//   stalls only when the result queue is full.
// Reset: synchronous, active high; clears both queues and all channel registers.
module pwm_timer_register_block_core #(
   parameter int NUM_CHANNELS = pwmt_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = pwmt_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [pwmt_pkg::CMD_W-1:0]    req_cmd,
   input  logic [pwmt_pkg::OFFSET_W-1:0] req_offset,
   input  logic [pwmt_pkg::DATA_W-1:0]   req_wdata,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [pwmt_pkg::DATA_W-1:0]   rsp_rdata,
   output logic                          rsp_bad_access,
   output logic                          rsp_timer_running
);
   import pwmt_pkg::*;

   localparam int OP_W  = $bits(op_type);
   localparam int RSP_W = $bits(rsp_type);

   op_type           op_dec;     // decoded item from the front stage
   op_type           op_head;    // oldest queued op, feeding the back stage
   logic [OP_W-1:0]  op_head_bits;
   logic             op_empty;
   rsp_type          rsp_new;    // result produced by the back stage
   rsp_type          rsp_head;
   logic [RSP_W-1:0] rsp_head_bits;
   logic             rsp_full;
   logic             back_go;    // one op transfers from op queue to result queue

   // Classify the incoming item.
   pwmt_front #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_front (
      .cmd    (req_cmd),
      .offset (req_offset),
      .wdata  (req_wdata),
      .op     (op_dec)
   );

   // Hold decoded ops so the front keeps accepting while the back stalls.
   pwmt_fifo #(
      .WIDTH(OP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (op_dec),
      .full  (req_full),
      .pop   (back_go),
      .dout  (op_head_bits),
      .empty (op_empty)
   );

   assign op_head = op_type'(op_head_bits);

   // Advance the back stage whenever an op waits and the result queue has room.
   assign back_go = !op_empty && !rsp_full;

   pwmt_back #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .go    (back_go),
      .op    (op_head),
      .rsp   (rsp_new)
   );

   // Hold finished results until the consumer pops them.
   pwmt_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (back_go),
      .din   (rsp_new),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_head_bits),
      .empty (rsp_empty)
   );

   assign rsp_head          = rsp_type'(rsp_head_bits);
   assign rsp_rdata         = rsp_head.rdata;
   assign rsp_bad_access    = rsp_head.bad_access;
   assign rsp_timer_running = rsp_head.timer_running;

   // An accepted item must be waiting in the op queue on the next cycle.
   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !op_empty)
      else $error("accepted item missing from op queue");

   // The back stage never pushes into a full result queue.
   a_no_rsp_overflow : assert property (@(posedge clock) disable iff (reset)
      back_go |-> !rsp_full)
      else $error("result pushed into full queue");

   // Ticks, writes and unused commands return zero read data.
   a_rdata_zero : assert property (@(posedge clock) disable iff (reset)
      (back_go && op_head.kind != OPK_READ) |-> (rsp_new.rdata == '0))
      else $error("non-read op returned read data");

   // Only bus accesses can flag a bad offset.
   a_bad_only_access : assert property (@(posedge clock) disable iff (reset)
      (back_go && (op_head.kind == OPK_TICK || op_head.kind == OPK_NOP))
         |-> !rsp_new.bad_access)
      else $error("tick or unused command flagged bad access");

endmodule

[sim/tb_pwm_timer_register_block_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pwm_timer_register_block_core: ticks, bus reads and writes.
// Depends on pwmt_pkg and the block's RTL; predicts every response in place.
module tb_pwm_timer_register_block_core;
   import pwmt_pkg::*;

   localparam int NCH         = NUM_CHANNELS_DEF;
   localparam int CW          = COUNT_WIDTH_DEF;
   localparam int RANDOM_OPS  = 1250;
   localparam int STALL_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;
   localparam int CALM_FIRST  = 500;
   localparam int CALM_LAST   = 800;
   localparam int IDLE_PCT    = 14;
   localparam logic [DATA_W-1:0] CNT_MASK = {DATA_W{1'b1}} >> (DATA_W - CW);

   // One bus operation; drain makes the sender hold off until nothing is outstanding.
   typedef struct {
      cmd_type             cmd;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   wdata;
      bit                  drain;
   } bus_op_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [CMD_W-1:0]    req_cmd = CMD_NOP;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [DATA_W-1:0]   req_wdata = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [DATA_W-1:0]   rsp_rdata;
   logic                rsp_bad_access;
   logic                rsp_timer_running;

   // Shadow copy of the timer registers.
   logic [NCH-1:0]    chan_en;
   logic [NCH-1:0]    chan_done;
   logic [CTRL_W-1:0] chan_ctrl [NCH];
   logic [DATA_W-1:0] chan_period [NCH];
   logic [DATA_W-1:0] chan_duty [NCH];
   logic [DATA_W-1:0] chan_cnt [NCH];

   bus_op_type bus_ops [$];
   rsp_type    expected_responses [$];
   bus_op_type op_on_bus;

   int unsigned ops_sent = 0;
   int unsigned rsp_checked = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_ticks = 0, n_reads = 0, n_writes = 0, n_nops = 0;
   int unsigned n_bad = 0, n_period_hits = 0;

   pwm_timer_register_block_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_offset        (req_offset),
      .req_wdata         (req_wdata),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_rdata         (rsp_rdata),
      .rsp_bad_access    (rsp_bad_access),
      .rsp_timer_running (rsp_timer_running)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one operation to the shadow registers and return the response it yields.
   function automatic rsp_type predict_bus_response(bus_op_type op);
      rsp_type     r;
      int unsigned ch;
      int          c;
      logic [3:0]  rsel;
      bit          chan_hit;
      r        = '0;
      ch       = 0;
      chan_hit = 1'b0;
      rsel     = op.offset[3:0];
      // Channel windows start at the base; anything past the last channel misses.
      if (op.offset != GLOBAL_OFFSET && op.offset >= CHAN_BASE) begin
         ch       = int'(op.offset - CHAN_BASE) >> 4;
         chan_hit = ch < NCH;
      end
      case (op.cmd)
         CMD_TICK: begin
            n_ticks++;
            for (c = 0; c < NCH; c++) begin
               if (chan_en[c]) begin
                  chan_cnt[c] = (chan_cnt[c] + 1) & CNT_MASK;
                  // Compare with at-or-above so a lowered period still fires.
                  if (chan_period[c] != '0 && chan_cnt[c] >= chan_period[c]) begin
                     chan_cnt[c]  = '0;
                     chan_done[c] = 1'b1;
                     n_period_hits++;
                  end
               end
            end
         end
         CMD_READ: begin
            n_reads++;
            if (op.offset == GLOBAL_OFFSET) begin
               r.rdata = DATA_W'(chan_en) | (DATA_W'(chan_done) << NCH);
            end else if (chan_hit) begin
               case (rsel)
                  REG_CTRL:   r.rdata = DATA_W'(chan_ctrl[ch]);
                  REG_PERIOD: r.rdata = chan_period[ch];
                  REG_DUTY:   r.rdata = chan_duty[ch];
                  REG_COUNT:  r.rdata = chan_cnt[ch];
                  default:    r.bad_access = 1'b1;
               endcase
            end else begin
               r.bad_access = 1'b1;
            end
         end
         CMD_WRITE: begin
            n_writes++;
            if (op.offset == GLOBAL_OFFSET) begin
               // Write one to clear; enables are not writable here.
               chan_done = chan_done & ~op.wdata[NCH +: NCH];
            end else if (chan_hit) begin
               case (rsel)
                  REG_CTRL: begin
                     chan_ctrl[ch] = op.wdata[CTRL_W-1:0];
                     chan_en[ch]   = op.wdata[CTRL_EN_BIT];
                  end
                  REG_PERIOD: chan_period[ch] = op.wdata & CNT_MASK;
                  REG_DUTY:   chan_duty[ch]   = op.wdata & CNT_MASK;
                  default:    r.bad_access = 1'b1;  // counter and holes
               endcase
            end else begin
               r.bad_access = 1'b1;
            end
         end
         default: n_nops++;
      endcase
      if (r.bad_access) n_bad++;
      r.timer_running = |chan_en;
      return r;
   endfunction

   task automatic queue_op(cmd_type cmd, logic [OFFSET_W-1:0] offset, logic [DATA_W-1:0] wdata);
      bus_op_type op;
      op.cmd    = cmd;
      op.offset = offset;
      op.wdata  = wdata;
      op.drain  = 1'b0;
      bus_ops.push_back(op);
   endtask

   // Mostly well-formed register offsets; the rest spans the whole byte range.
   function automatic logic [OFFSET_W-1:0] pick_offset();
      logic [3:0] rsel;
      logic [3:0] win;
      if ($urandom_range(99) < 15) return OFFSET_W'($urandom_range(255));
      if ($urandom_range(9) == 0) return GLOBAL_OFFSET;
      case ($urandom_range(3))
         0:       rsel = REG_CTRL;
         1:       rsel = REG_PERIOD;
         2:       rsel = REG_DUTY;
         default: rsel = REG_COUNT;
      endcase
      win = 4'($urandom_range(NCH - 1) + (CHAN_BASE >> 4));
      return {win, rsel};
   endfunction

   // Small periods keep done flags firing; full-range values cover the wide bits.
   function automatic bus_op_type random_bus_op();
      bus_op_type  op;
      int unsigned roll;
      roll      = $urandom_range(99);
      op.drain  = 1'b0;
      op.offset = pick_offset();
      op.wdata  = $urandom;
      if (roll < 30) begin
         op.cmd    = CMD_TICK;
         op.offset = OFFSET_W'($urandom_range(255));
      end else if (roll < 62) begin
         op.cmd = CMD_READ;
      end else if (roll < 97) begin
         op.cmd = CMD_WRITE;
         if (op.offset[3:0] == REG_PERIOD && op.offset != GLOBAL_OFFSET) begin
            case ($urandom_range(9))
               0:       op.wdata = '0;
               1, 2:    op.wdata = $urandom;
               default: op.wdata = DATA_W'($urandom_range(12, 1));
            endcase
         end else if (op.offset[3:0] == REG_CTRL && $urandom_range(3) != 0) begin
            op.wdata[CTRL_EN_BIT] = 1'b1;  // favor enabled channels
         end
      end else begin
         op.cmd = CMD_NOP;
      end
      return op;
   endfunction

   // Driver: predict at the push transfer, hold while full, then offer the next op.
   always @(posedge clock) begin
      bit offer;
      bit calm;
      offer = 1'b0;
      calm  = ops_sent >= CALM_FIRST && ops_sent < CALM_LAST;
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && req_full) begin
         // hold the current op until the block takes it
      end else begin
         if (req_push) begin
            expected_responses.push_back(predict_bus_response(op_on_bus));
            ops_sent++;
         end
         if (bus_ops.size() != 0 && !(bus_ops[0].drain && expected_responses.size() != 0))
            offer = calm || $urandom_range(99) >= IDLE_PCT;
         if (offer) begin
            op_on_bus  = bus_ops.pop_front();
            req_cmd    <= op_on_bus.cmd;
            req_offset <= op_on_bus.offset;
            req_wdata  <= op_on_bus.wdata;
         end
         req_push <= offer;
      end
   end

   // Monitor: check each pop transfer against the oldest prediction, then stall at random.
   always @(posedge clock) begin
      rsp_type want;
      bit      calm;
      calm = rsp_checked >= CALM_FIRST && rsp_checked < CALM_LAST;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response with nothing outstanding: rdata %h bad %b run %b",
                           $realtime, rsp_rdata, rsp_bad_access, rsp_timer_running);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_rdata !== want.rdata || rsp_bad_access !== want.bad_access ||
                   rsp_timer_running !== want.timer_running) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: response %0d: rdata %h/%h bad %b/%b run %b/%b (exp/got)",
                              $realtime, rsp_checked, want.rdata, rsp_rdata,
                              want.bad_access, rsp_bad_access,
                              want.timer_running, rsp_timer_running);
               end
            end
            rsp_checked++;
         end
         rsp_pop <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // Watchdog: give up when neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("pwm_timer_register_block_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bus_op_type  op;
      int          i;
      int unsigned failures;
      int unsigned total_ops;
      chan_en   = '0;
      chan_done = '0;
      for (i = 0; i < NCH; i++) begin
         chan_ctrl[i]   = '0;
         chan_period[i] = '0;
         chan_duty[i]   = '0;
         chan_cnt[i]    = '0;
      end

      // Directed: reset values, every command, field extremes and each corner.
      queue_op(CMD_READ,  GLOBAL_OFFSET, '0);
      queue_op(CMD_WRITE, 8'h10, 32'hFFFF_FFFF);    // ch0 on, control keeps four bits
      queue_op(CMD_WRITE, 8'h14, 32'd1);            // ch0 fires on every tick
      queue_op(CMD_TICK,  8'h00, 32'h0);
      queue_op(CMD_READ,  GLOBAL_OFFSET, '0);       // enable and done both visible
      queue_op(CMD_WRITE, GLOBAL_OFFSET, 32'hFFFF_FFFF);
      queue_op(CMD_WRITE, 8'h44, 32'hFFFF_FFFF);    // ch3 widest period
      queue_op(CMD_WRITE, 8'h48, 32'hAAAA_5555);
      queue_op(CMD_WRITE, 8'h40, 32'h0000_0001);
      queue_op(CMD_WRITE, 8'h20, 32'h0000_000E);    // ch1 control without enable
      queue_op(CMD_TICK,  8'hFF, 32'hFFFF_FFFF);    // tick ignores offset and data
      queue_op(CMD_TICK,  8'h55, 32'h1234_5678);
      queue_op(CMD_TICK,  8'hAA, 32'h0);
      queue_op(CMD_WRITE, 8'h44, 32'd2);            // period dropped below count
      queue_op(CMD_TICK,  8'h00, 32'h0);
      queue_op(CMD_WRITE, 8'h4C, 32'hFFFF_FFFF);    // counter is read only
      queue_op(CMD_READ,  8'h4C, '0);
      queue_op(CMD_READ,  8'h01, '0);               // hole under the first channel
      queue_op(CMD_WRITE, 8'h0F, 32'hFFFF_FFFF);
      queue_op(CMD_READ,  8'h12, '0);               // hole inside a channel window
      queue_op(CMD_READ,  8'h50, '0);               // first missing channel
      queue_op(CMD_READ,  8'hFF, '0);
      queue_op(CMD_NOP,   8'hFF, 32'hFFFF_FFFF);
      queue_op(CMD_READ,  8'h48, '0);
      queue_op(CMD_WRITE, 8'h10, 32'h0000_0000);    // ch0 off

      // Random traffic; a few ops wait for the pipeline to empty first.
      for (i = 0; i < RANDOM_OPS; i++) begin
         op       = random_bus_op();
         op.drain = i == 0 || i == 400 || i == 950;
         bus_ops.push_back(op);
      end
      total_ops = bus_ops.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait until every op has transferred, then the responses, then watch for strays.
      while (ops_sent < total_ops) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      failures = mismatches + expected_responses.size();
      $display("Covered %0d ops: %0d ticks, %0d reads, %0d writes, %0d unused commands.",
               ops_sent, n_ticks, n_reads, n_writes, n_nops);
      $display("Period expiries %0d, rejected accesses %0d, responses checked %0d.",
               n_period_hits, n_bad, rsp_checked);
      if (failures == 0) begin
         $display("pwm_timer_register_block_core verification clean");
      end else begin
         $display("pwm_timer_register_block_core verification failed");
      end
      $finish;
   end

endmodule
